[rtl/core/ps2mct_pkg.sv]
package ps2mct_pkg;

   localparam int unsigned POS_WIDTH  = 12;
   localparam int unsigned BYTE_WIDTH = 8;
   localparam int unsigned MAG_WIDTH  = 9;   // 0..256
   localparam int unsigned CSR_INDEX_WIDTH = 1;

   localparam logic [POS_WIDTH-1:0] MAX_X_RESET = 12'd1024;
   localparam logic [POS_WIDTH-1:0] MAX_Y_RESET = 12'd768;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_X = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_Y = 1'd1;

   // status byte bit positions
   localparam int unsigned ST_LEFT  = 0;
   localparam int unsigned ST_RIGHT = 1;
   localparam int unsigned ST_XSIGN = 4;
   localparam int unsigned ST_YSIGN = 5;

   typedef enum logic [1:0] {
      BTN_UP    = 2'd0,
      BTN_CLICK = 2'd1,
      BTN_DOWN  = 2'd2
   } button_state_type;

   typedef logic [POS_WIDTH-1:0] pos_type;

   function automatic button_state_type button_next(button_state_type cur, logic pressed);
      button_state_type nxt;
      nxt = cur;
      if (!pressed) begin
         nxt = BTN_UP;
      end else begin
         unique case (cur)
            BTN_UP:    nxt = BTN_CLICK;
            BTN_CLICK: nxt = BTN_DOWN;
            default:   nxt = cur;
         endcase
      end
      return nxt;
   endfunction

   // magnitude of a movement byte: 256 - byte when the sign is set
   function automatic logic [MAG_WIDTH-1:0] move_mag(logic [BYTE_WIDTH-1:0] b, logic neg);
      logic [MAG_WIDTH-1:0] m;
      m = {1'b0, b};
      if (neg) begin
         m = 9'd256 - {1'b0, b};
      end
      return m;
   endfunction

   function automatic pos_type move_toward_zero(pos_type pos, logic [MAG_WIDTH-1:0] mag);
      logic [POS_WIDTH-1:0] mag_ext;
      pos_type r;
      mag_ext = {{(POS_WIDTH-MAG_WIDTH){1'b0}}, mag};
      r = (mag_ext >= pos) ? '0 : pos - mag_ext;
      return r;
   endfunction

   function automatic pos_type move_away(pos_type pos, logic [MAG_WIDTH-1:0] mag, pos_type lim);
      logic [POS_WIDTH:0] s;
      pos_type r;
      s = {1'b0, pos} + {{(POS_WIDTH+1-MAG_WIDTH){1'b0}}, mag};
      r = (s > {1'b0, lim}) ? lim : s[POS_WIDTH-1:0];
      return r;
   endfunction

endpackage

[rtl/core/ps2_mouse_cursor_tracker_top.sv]
// PS/2 mouse cursor tracker.
// Request channel (req_*): one assembled three-byte mouse packet per beat
// (status, X movement, Y movement), valid/stall handshake.
// Response channel (rsp_*): one beat per packet carrying the cursor X/Y after
// that packet and the left/right button states (0 up, 1 click, 2 down).
// Response valid rises in the cycle after a request beat is taken; one packet
// per cycle is sustained unless the receiver stalls, set by the single update
// stage feeding the output register. Cursor and button state update as the
// request beat is taken. When the receiver stalls, the response register holds
// its beat and req_stall rises only while that beat is held; a new request is
// taken in the same cycle the held beat drains.
// Configuration: csr_write_en with csr_index 0 (max X) or 1 (max Y) and
// csr_wdata; write only while idle.
// Reset (synchronous, active high) puts the cursor at 0,0, both buttons up,
// limits to 1024 x 768, and empties the response register.
module ps2_mouse_cursor_tracker_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ps2mct_pkg::BYTE_WIDTH-1:0]    req_status_byte,
   input  logic [ps2mct_pkg::BYTE_WIDTH-1:0]    req_dx_byte,
   input  logic [ps2mct_pkg::BYTE_WIDTH-1:0]    req_dy_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ps2mct_pkg::POS_WIDTH-1:0]     rsp_pos_x,
   output logic [ps2mct_pkg::POS_WIDTH-1:0]     rsp_pos_y,
   output logic [1:0]                           rsp_left_state,
   output logic [1:0]                           rsp_right_state,
   input  logic                                 csr_write_en,
   input  logic [ps2mct_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ps2mct_pkg::POS_WIDTH-1:0]     csr_wdata
);
   import ps2mct_pkg::*;

   pos_type          max_x_ff, max_x_in;
   pos_type          max_y_ff, max_y_in;
   pos_type          cur_x_ff, cur_x_in;
   pos_type          cur_y_ff, cur_y_in;
   button_state_type left_ff, left_in;
   button_state_type right_ff, right_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic                 accept;
   logic                 xneg, yneg;
   logic [MAG_WIDTH-1:0] mag_x, mag_y;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign xneg  = req_status_byte[ST_XSIGN];
   assign yneg  = req_status_byte[ST_YSIGN];
   assign mag_x = move_mag(req_dx_byte, xneg);
   assign mag_y = move_mag(req_dy_byte, yneg);

   always_comb begin
      max_x_in = max_x_ff;
      max_y_in = max_y_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_MAX_X: max_x_in = csr_wdata;
            CSR_MAX_Y: max_y_in = csr_wdata;
            default:   ;
         endcase
      end
   end

   always_comb begin
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         cur_x_in     = xneg ? move_toward_zero(cur_x_ff, mag_x)
                             : move_away(cur_x_ff, mag_x, max_x_ff);
         // Y grows downward: a negative move goes away from zero
         cur_y_in     = yneg ? move_away(cur_y_ff, mag_y, max_y_ff)
                             : move_toward_zero(cur_y_ff, mag_y);
         left_in      = button_next(left_ff, req_status_byte[ST_LEFT]);
         right_in     = button_next(right_ff, req_status_byte[ST_RIGHT]);
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_x_ff     <= MAX_X_RESET;
         max_y_ff     <= MAX_Y_RESET;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         left_ff      <= BTN_UP;
         right_ff     <= BTN_UP;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_x_ff     <= max_x_in;
         max_y_ff     <= max_y_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // state registers double as the response payload
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x       = cur_x_ff;
   assign rsp_pos_y       = cur_y_ff;
   assign rsp_left_state  = left_ff;
   assign rsp_right_state = right_ff;

endmodule

[tb/tb_ps2_mouse_cursor_tracker_top.sv]
module tb_ps2_mouse_cursor_tracker_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ps2mct_pkg::*;

   localparam int CYCLE_LIMIT   = 100000;
   localparam int PHASE_PACKETS = 100;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      pos_type          pos_x;
      pos_type          pos_y;
      button_state_type left;
      button_state_type right;
   } cursor_report_type;

   class cursor_scoreboard;
      pos_type           cur_x;
      pos_type           cur_y;
      pos_type           lim_x;
      pos_type           lim_y;
      button_state_type  left_btn;
      button_state_type  right_btn;
      cursor_report_type pending_reports[$];
      int                mismatches;

      function new();
         cur_x      = '0;
         cur_y      = '0;
         lim_x      = 12'd1024;
         lim_y      = 12'd768;
         left_btn   = BTN_UP;
         right_btn  = BTN_UP;
         mismatches = 0;
      endfunction

      function void set_limit(logic [CSR_INDEX_WIDTH-1:0] index, pos_type value);
         if (index == CSR_MAX_X) begin
            lim_x = value;
         end else begin
            lim_y = value;
         end
      endfunction

      function button_state_type step_button(button_state_type cur, bit held);
         if (!held) begin
            return BTN_UP;
         end
         if (cur == BTN_UP) begin
            return BTN_CLICK;
         end
         if (cur == BTN_CLICK) begin
            return BTN_DOWN;
         end
         return cur;
      endfunction

      function pos_type shift_pos(pos_type pos, bit toward_zero, int mag, pos_type lim);
         int p;
         int l;
         p = int'(pos);
         l = int'(lim);
         if (toward_zero) begin
            return (mag >= p) ? pos_type'(0) : pos_type'(p - mag);
         end
         return (p + mag > l) ? lim : pos_type'(p + mag);
      endfunction

      function void note_packet(bit [7:0] st, bit [7:0] dx, bit [7:0] dy);
         int                mag_x;
         int                mag_y;
         cursor_report_type r;
         mag_x = st[ST_XSIGN] ? 256 - int'(dx) : int'(dx);
         mag_y = st[ST_YSIGN] ? 256 - int'(dy) : int'(dy);
         right_btn = step_button(right_btn, st[ST_RIGHT]);
         left_btn  = step_button(left_btn, st[ST_LEFT]);
         cur_x = shift_pos(cur_x, st[ST_XSIGN], mag_x, lim_x);
         // Y grows downward: a negative move pushes away from zero
         cur_y = shift_pos(cur_y, !st[ST_YSIGN], mag_y, lim_y);
         r.pos_x = cur_x;
         r.pos_y = cur_y;
         r.left  = left_btn;
         r.right = right_btn;
         pending_reports.push_back(r);
      endfunction

      function void check_report(pos_type x, pos_type y, logic [1:0] l, logic [1:0] r);
         cursor_report_type want;
         if (pending_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("%0t: unexpected beat x=%0d y=%0d left=%0d right=%0d",
                        $realtime, x, y, l, r);
            end
            return;
         end
         want = pending_reports.pop_front();
         if (x !== want.pos_x || y !== want.pos_y ||
             l !== 2'(want.left) || r !== 2'(want.right)) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("%0t: mismatch exp x=%0d y=%0d left=%0d right=%0d",
                        $realtime, want.pos_x, want.pos_y, want.left, want.right);
               $display("%0t:          got x=%0d y=%0d left=%0d right=%0d",
                        $realtime, x, y, l, r);
            end
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [BYTE_WIDTH-1:0]      req_status_byte;
   logic [BYTE_WIDTH-1:0]      req_dx_byte;
   logic [BYTE_WIDTH-1:0]      req_dy_byte;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [POS_WIDTH-1:0]       rsp_pos_x;
   logic [POS_WIDTH-1:0]       rsp_pos_y;
   logic [1:0]                 rsp_left_state;
   logic [1:0]                 rsp_right_state;
   logic                       csr_write_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [POS_WIDTH-1:0]       csr_wdata;

   cursor_scoreboard board;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               cycle_count   = 0;

   // status, dx, dy: walks the cursor into both corners under the default limits
   bit [23:0] directed_packets [0:21] = '{
      24'h00_00_00, 24'h30_00_00, 24'h01_ff_00, 24'h03_ff_01,
      24'h03_ff_ff, 24'h02_ff_00, 24'h22_ff_80, 24'h20_00_01,
      24'h20_00_01, 24'h20_00_01, 24'hc0_00_00, 24'h04_00_00,
      24'h10_01_00, 24'h10_00_00, 24'h10_00_00, 24'h10_00_00,
      24'h10_ff_00, 24'h0f_7f_7f, 24'hff_80_80, 24'h31_01_01,
      24'h33_80_ff, 24'h08_00_80
   };

   ps2_mouse_cursor_tracker_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_status_byte (req_status_byte),
      .req_dx_byte     (req_dx_byte),
      .req_dy_byte     (req_dy_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_left_state  (rsp_left_state),
      .rsp_right_state (rsp_right_state),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_packet(input bit [7:0] st, input bit [7:0] dx, input bit [7:0] dy);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_status_byte <= st;
      req_dx_byte     <= dx;
      req_dy_byte     <= dy;
      do @(posedge clock); while (req_stall);
      board.note_packet(st, dx, dy);
   endtask

   // caller has already dropped req_valid in this step
   task automatic wait_drained();
      while (board.pending_reports.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_limits(input pos_type lim_x, input pos_type lim_y);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_MAX_X;
      csr_wdata    <= lim_x;
      @(posedge clock);
      board.set_limit(CSR_MAX_X, lim_x);
      csr_index    <= CSR_MAX_Y;
      csr_wdata    <= lim_y;
      @(posedge clock);
      board.set_limit(CSR_MAX_Y, lim_y);
      csr_write_en <= 1'b0;
   endtask

   // response side: random stall, check every beat taken
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            board.check_report(rsp_pos_x, rsp_pos_y, rsp_left_state, rsp_right_state);
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   initial begin
      bit [7:0] st;
      bit [7:0] dx;
      bit [7:0] dy;
      bit       drift_x;
      bit       drift_y;
      bit       hold_l;
      bit       hold_r;
      pos_type  lim_x;
      pos_type  lim_y;

      board = new();
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_status_byte <= '0;
      req_dx_byte     <= '0;
      req_dy_byte     <= '0;
      csr_write_en    <= 1'b0;
      csr_index       <= CSR_MAX_X;
      csr_wdata       <= '0;
      drift_x = 1'b0;
      drift_y = 1'b0;
      hold_l  = 1'b0;
      hold_r  = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 32;
      recv_idle_pct = 75;
      foreach (directed_packets[i]) begin
         send_packet(directed_packets[i][23:16], directed_packets[i][15:8],
                     directed_packets[i][7:0]);
      end

      for (int p = 0; p < 4; p++) begin
         req_valid <= 1'b0;
         wait_drained();
         case (p)
            0: begin
               send_idle_pct = 32;
               recv_idle_pct = 75;
               lim_x = 12'd4095;
               lim_y = 12'd4095;
            end
            1: begin
               // limits drop under a cursor left high by the last phase
               send_idle_pct = 75;
               recv_idle_pct = 32;
               lim_x = pos_type'($urandom_range(1, 40));
               lim_y = '0;
            end
            2: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               lim_x = '0;
               lim_y = 12'd4095;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               lim_x = pos_type'($urandom_range(0, 4095));
               lim_y = pos_type'($urandom_range(0, 4095));
            end
         endcase
         write_limits(lim_x, lim_y);

         for (int n = 0; n < PHASE_PACKETS; n++) begin
            // drift one way for a stretch so the cursor reaches both walls
            if ($urandom_range(29) == 0) drift_x = ~drift_x;
            if ($urandom_range(29) == 0) drift_y = ~drift_y;
            if ($urandom_range(3) == 0) hold_l = ~hold_l;
            if ($urandom_range(3) == 0) hold_r = ~hold_r;
            st = 8'($urandom);
            st[ST_XSIGN] = ($urandom_range(9) < 8) ? drift_x : ~drift_x;
            st[ST_YSIGN] = ($urandom_range(9) < 8) ? drift_y : ~drift_y;
            st[ST_LEFT]  = hold_l;
            st[ST_RIGHT] = hold_r;
            dx = 8'($urandom);
            dy = 8'($urandom);
            send_packet(st, dx, dy);
         end
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (2) @(posedge clock);
      if (board.mismatches == 0 && board.pending_reports.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/ps2mct_pkg.sv
rtl/core/ps2_mouse_cursor_tracker_top.sv
tb/tb_ps2_mouse_cursor_tracker_top.sv
